@@ rtl/bpied_pkg.sv @@
package bpied_pkg;

    // default for the longest query the pattern store holds
    localparam int DEF_MAX_QUERY_LEN = 64;

    // fixed field widths
    localparam int LEN_W    = 7;
    localparam int POS_W    = 6;
    localparam int SYMBOL_W = 8;
    localparam int CMD_W    = 2;

    // command codes, code 3 is unused and ignored
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_TARGET = 2'd1,
        CMD_EMPTY  = 2'd2
    } cmd_t;

    // ascii codes for the nucleotide letters
    localparam logic [SYMBOL_W-1:0] CH_A_UP = 8'h41;
    localparam logic [SYMBOL_W-1:0] CH_A_LO = 8'h61;
    localparam logic [SYMBOL_W-1:0] CH_C_UP = 8'h43;
    localparam logic [SYMBOL_W-1:0] CH_C_LO = 8'h63;
    localparam logic [SYMBOL_W-1:0] CH_G_UP = 8'h47;
    localparam logic [SYMBOL_W-1:0] CH_G_LO = 8'h67;
    localparam logic [SYMBOL_W-1:0] CH_T_UP = 8'h54;
    localparam logic [SYMBOL_W-1:0] CH_T_LO = 8'h74;

    // lower case a, c, g, t fold to upper case, all else unchanged
    function automatic logic [SYMBOL_W-1:0] fold_dna(input logic [SYMBOL_W-1:0] c);
        logic [SYMBOL_W-1:0] r;
        r = c;
        if (c == CH_A_LO) r = CH_A_UP;
        if (c == CH_C_LO) r = CH_C_UP;
        if (c == CH_G_LO) r = CH_G_UP;
        if (c == CH_T_LO) r = CH_T_UP;
        return r;
    endfunction

    // control from the item stage to the recurrence unit
    typedef struct packed {
        logic start;   // reset deltas and scores before any step
        logic step;    // advance the recurrence by one target byte
    } step_ctl_t;

endpackage

@@ rtl/bit_parallel_infix_edit_distance_core.sv @@
// channel   direction  handshake               payload
// input     in         in_valid / in_ready     command, position, symbol, first, last
// config    in         cfg_valid / cfg_ready   cfg_data (query_length)
// result    out        out_valid / out_ready   distance
//
// every transaction passes through the item register, whose outputs run through the compare
// lanes and the MAX_QUERY_LEN-bit add of the recurrence straight into the result register;
// out_valid is registered with the result; a new transaction is taken every cycle unless stalled
// rst_n is asynchronous: deltas, scores and query length go to their reset values,
// the query store itself is not cleared
// a stalled result holds the item stage only when that item also yields a result
module bit_parallel_infix_edit_distance_core #(
    parameter int MAX_QUERY_LEN = bpied_pkg::DEF_MAX_QUERY_LEN
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bpied_pkg::CMD_W-1:0]   command,
    input  logic [bpied_pkg::POS_W-1:0]   position,
    input  logic [bpied_pkg::SYMBOL_W-1:0] symbol,
    input  logic                          first,
    input  logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bpied_pkg::LEN_W-1:0]   cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bpied_pkg::LEN_W-1:0]   distance
);

    localparam logic [bpied_pkg::LEN_W-1:0] LEN_MAX = bpied_pkg::LEN_W'(MAX_QUERY_LEN);

    // item register
    logic                           pipe_valid_reg;
    logic [bpied_pkg::CMD_W-1:0]    cmd_reg;
    logic [bpied_pkg::POS_W-1:0]    pos_reg;
    logic [bpied_pkg::SYMBOL_W-1:0] sym_reg;
    logic                           first_reg;
    logic                           last_reg;

    // configuration and result registers
    logic [bpied_pkg::LEN_W-1:0]    qlen_reg;
    logic                           out_valid_reg;
    logic [bpied_pkg::LEN_W-1:0]    distance_reg;

    logic [bpied_pkg::LEN_W-1:0]    len_eff;
    logic [bpied_pkg::LEN_W-1:0]    best_next;
    logic [bpied_pkg::LEN_W-1:0]    result_val;
    logic [MAX_QUERY_LEN-1:0]       eq;
    logic                           has_result;
    logic                           load_en;
    logic                           pipe_adv;
    bpied_pkg::step_ctl_t           ctl;

    // the length register is clamped into 1..MAX_QUERY_LEN where it is used
    always_comb
    begin
        len_eff = qlen_reg;
        if (qlen_reg == '0)
        begin
            len_eff = bpied_pkg::LEN_W'(1);
        end
        else if (qlen_reg > LEN_MAX)
        begin
            len_eff = LEN_MAX;
        end
    end

    // command decode for the item in the register
    always_comb
    begin
        has_result = 1'b0;
        load_en    = 1'b0;
        ctl        = '0;
        result_val = best_next;
        unique case (cmd_reg)
            bpied_pkg::CMD_LOAD:
            begin
                load_en = 1'b1;
            end
            bpied_pkg::CMD_TARGET:
            begin
                ctl.start  = first_reg;
                ctl.step   = 1'b1;
                has_result = last_reg;
            end
            bpied_pkg::CMD_EMPTY:
            begin
                ctl.start  = 1'b1;
                has_result = 1'b1;
                result_val = len_eff;
            end
            default:
            begin
                // unused code, dropped without effect
            end
        endcase
        has_result = has_result && pipe_valid_reg;
    end

    // the item moves on unless its result would land on an untaken one
    assign pipe_adv = pipe_valid_reg && (!has_result || !out_valid_reg || out_ready);
    assign in_ready = !pipe_valid_reg || pipe_adv;

    // writes to the config register are always taken
    assign cfg_ready = 1'b1;

    bpied_query_store #(
        .MAX_QUERY_LEN(MAX_QUERY_LEN)
    ) u_store (
        .clk    (clk),
        .wr_en  (pipe_adv && load_en),
        .wr_pos (pos_reg),
        .wr_sym (sym_reg),
        .rd_sym (sym_reg),
        .len_eff(len_eff),
        .eq     (eq)
    );

    bpied_myers_step #(
        .MAX_QUERY_LEN(MAX_QUERY_LEN)
    ) u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (pipe_adv ? ctl : '0),
        .eq       (eq),
        .len_eff  (len_eff),
        .best_next(best_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            qlen_reg       <= bpied_pkg::LEN_W'(64);
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                pipe_valid_reg <= 1'b1;
            end
            else if (pipe_adv)
            begin
                pipe_valid_reg <= 1'b0;
            end

            if (pipe_adv && has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid)
            begin
                qlen_reg <= cfg_data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg   <= command;
            pos_reg   <= position;
            sym_reg   <= symbol;
            first_reg <= first;
            last_reg  <= last;
        end
        if (pipe_adv && has_result)
        begin
            distance_reg <= result_val;
        end
    end

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;

endmodule

@@ rtl/bpied_query_store.sv @@
module bpied_query_store #(
    parameter int MAX_QUERY_LEN = bpied_pkg::DEF_MAX_QUERY_LEN
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [bpied_pkg::POS_W-1:0]   wr_pos,
    input  logic [bpied_pkg::SYMBOL_W-1:0] wr_sym,
    input  logic [bpied_pkg::SYMBOL_W-1:0] rd_sym,
    input  logic [bpied_pkg::LEN_W-1:0]   len_eff,
    output logic [MAX_QUERY_LEN-1:0]      eq
);

    // query bytes kept already folded, no reset (undefined until written)
    logic [bpied_pkg::SYMBOL_W-1:0] qbyte_reg [MAX_QUERY_LEN];
    logic [bpied_pkg::SYMBOL_W-1:0] rd_fold;

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MAX_QUERY_LEN; j++)
        begin
            if (wr_en && (wr_pos == bpied_pkg::POS_W'(j)))
            begin
                qbyte_reg[j] <= bpied_pkg::fold_dna(wr_sym);
            end
        end
    end

    assign rd_fold = bpied_pkg::fold_dna(rd_sym);

    // one comparator per lane, lanes at or above the length masked off
    always_comb
    begin
        for (int j = 0; j < MAX_QUERY_LEN; j++)
        begin
            eq[j] = (qbyte_reg[j] == rd_fold) && (bpied_pkg::LEN_W'(j) < len_eff);
        end
    end

endmodule

@@ rtl/bpied_myers_step.sv @@
module bpied_myers_step #(
    parameter int MAX_QUERY_LEN = bpied_pkg::DEF_MAX_QUERY_LEN
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bpied_pkg::step_ctl_t        ctl,
    input  logic [MAX_QUERY_LEN-1:0]    eq,
    input  logic [bpied_pkg::LEN_W-1:0] len_eff,
    output logic [bpied_pkg::LEN_W-1:0] best_next
);

    localparam logic [bpied_pkg::LEN_W-1:0] SCORE_MAX = '1;

    logic [MAX_QUERY_LEN-1:0]    vp_reg, vp_next, vn_reg, vn_next;
    logic [bpied_pkg::LEN_W-1:0] score_reg, score_next, best_reg;
    logic [MAX_QUERY_LEN-1:0]    vp_cur, vn_cur, xv, xh, ph, mh, top_sel;
    logic [bpied_pkg::LEN_W-1:0] score_cur, best_cur, score_step;
    logic                        ph_top, mh_top;

    // a target start puts the reset values in front of the step
    assign vp_cur    = ctl.start ? '1 : vp_reg;
    assign vn_cur    = ctl.start ? '0 : vn_reg;
    assign score_cur = ctl.start ? len_eff : score_reg;
    assign best_cur  = ctl.start ? len_eff : best_reg;

    always_comb
    begin
        for (int j = 0; j < MAX_QUERY_LEN; j++)
        begin
            top_sel[j] = (len_eff == bpied_pkg::LEN_W'(j + 1));
        end
    end

    assign xv = eq | vn_cur;
    assign xh = (((eq & vp_cur) + vp_cur) ^ vp_cur) | eq;
    assign ph = vn_cur | ~(xh | vp_cur);
    assign mh = vp_cur & xh;

    assign ph_top = |(ph & top_sel);
    assign mh_top = |(mh & top_sel);

    // saturating score update from the top horizontal deltas
    always_comb
    begin
        score_step = score_cur;
        if (ph_top && !mh_top && (score_cur != SCORE_MAX))
        begin
            score_step = score_cur + 1'b1;
        end
        else if (mh_top && !ph_top && (score_cur != '0))
        begin
            score_step = score_cur - 1'b1;
        end
    end

    always_comb
    begin
        vp_next    = vp_cur;
        vn_next    = vn_cur;
        score_next = score_cur;
        best_next  = best_cur;
        if (ctl.step)
        begin
            vp_next    = (mh << 1) | ~(xv | (ph << 1));
            vn_next    = (ph << 1) & xv;
            score_next = score_step;
            best_next  = (score_step < best_cur) ? score_step : best_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg    <= '1;
            vn_reg    <= '0;
            score_reg <= bpied_pkg::LEN_W'(MAX_QUERY_LEN);
            best_reg  <= bpied_pkg::LEN_W'(MAX_QUERY_LEN);
        end
        else if (ctl.start || ctl.step)
        begin
            vp_reg    <= vp_next;
            vn_reg    <= vn_next;
            score_reg <= score_next;
            best_reg  <= best_next;
        end
    end

endmodule

@@ sim/distance_scoreboard_pkg.sv @@
package distance_scoreboard_pkg;

    import bpied_pkg::*;

    localparam int QUERY_DEPTH = DEF_MAX_QUERY_LEN;

    class distance_scoreboard;

        logic [SYMBOL_W-1:0]    query_store [QUERY_DEPTH];
        logic [QUERY_DEPTH-1:0] pos_delta;
        logic [QUERY_DEPTH-1:0] neg_delta;
        int                     running;
        int                     best;
        logic [LEN_W-1:0]       query_len;
        logic [LEN_W-1:0]       expected_distances [$];
        int                     mismatches;

        function new();
            foreach (query_store[i])
                query_store[i] = '0;
            query_len  = LEN_W'(QUERY_DEPTH);
            mismatches = 0;
            restart_target();
        endfunction

        // zero counts as one, anything past the store depth as the full depth
        function int active_length();
            int m;
            m = int'(query_len);
            if (m < 1)
                m = 1;
            if (m > QUERY_DEPTH)
                m = QUERY_DEPTH;
            return m;
        endfunction

        function logic [SYMBOL_W-1:0] fold_case(logic [SYMBOL_W-1:0] c);
            case (c)
                CH_A_LO: return CH_A_UP;
                CH_C_LO: return CH_C_UP;
                CH_G_LO: return CH_G_UP;
                CH_T_LO: return CH_T_UP;
                default: return c;
            endcase
        endfunction

        function void restart_target();
            pos_delta = '1;
            neg_delta = '0;
            running   = active_length();
            best      = active_length();
        endfunction

        // one column of the bit-parallel recurrence, zero carry-in at the first row
        function void advance_column(logic [SYMBOL_W-1:0] sym);
            logic [QUERY_DEPTH-1:0] eq;
            logic [QUERY_DEPTH-1:0] xv;
            logic [QUERY_DEPTH-1:0] xh;
            logic [QUERY_DEPTH-1:0] ph;
            logic [QUERY_DEPTH-1:0] mh;
            int                     m;
            int                     top;
            int                     score;
            m   = active_length();
            top = m - 1;
            eq  = '0;
            for (int j = 0; j < m; j++)
                if (fold_case(query_store[j]) == fold_case(sym))
                    eq[j] = 1'b1;
            xv    = eq | neg_delta;
            xh    = (((eq & pos_delta) + pos_delta) ^ pos_delta) | eq;
            ph    = neg_delta | ~(xh | pos_delta);
            mh    = pos_delta & xh;
            score = running + int'(ph[top]) - int'(mh[top]);
            if (score < 0)
                score = 0;
            if (score > 127)
                score = 127;
            running = score;
            if (running < best)
                best = running;
            ph        = ph << 1;
            mh        = mh << 1;
            pos_delta = mh | ~(xv | ph);
            neg_delta = ph & xv;
        endfunction

        function void set_query_length(logic [LEN_W-1:0] v);
            query_len = v;
        endfunction

        function void note_transaction(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                       logic [SYMBOL_W-1:0] sym, logic starts, logic ends);
            case (cmd)
                CMD_LOAD:
                    query_store[pos] = sym;
                CMD_EMPTY:
                begin
                    restart_target();
                    expected_distances.push_back(LEN_W'(active_length()));
                end
                CMD_TARGET:
                begin
                    if (starts)
                        restart_target();
                    advance_column(sym);
                    if (ends)
                        expected_distances.push_back(LEN_W'(best));
                end
                default:
                    ;
            endcase
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        task check_distance(logic [LEN_W-1:0] got);
            logic [LEN_W-1:0] want;
            if (expected_distances.size() == 0)
                report($sformatf("distance %0d with nothing pending", got));
            else
            begin
                want = expected_distances.pop_front();
                if (got !== want)
                    report($sformatf("distance %0d, expected %0d", got, want));
            end
        endtask

        function int pending();
            return expected_distances.size();
        endfunction

    endclass

endpackage

@@ sim/testbench.sv @@
module testbench;

    import bpied_pkg::*;
    import distance_scoreboard_pkg::*;

    // spare command code, the block must drop it silently
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int IDLE_LIMIT    = 5000;  // cycles with no transaction at all
    localparam int SETTLE_CYCLES = 4;     // two-stage pipe plus margin
    localparam int PHASE_ITEMS   = 88;
    localparam int PHASE_COUNT   = 11;
    localparam int BURST_ITEMS   = 40;

    localparam logic [SYMBOL_W-1:0] DNA_LETTERS [8] = '{
        CH_A_UP, CH_A_LO, CH_C_UP, CH_C_LO, CH_G_UP, CH_G_LO, CH_T_UP, CH_T_LO
    };

    // fixed query lengths for the first phases, the rest are random
    localparam logic [LEN_W-1:0] FIXED_LENGTHS [7] = '{
        7'd1, 7'd0, 7'd127, 7'd65, 7'd64, 7'd2, 7'd63
    };

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_ready;
    logic [CMD_W-1:0]    command      = CMD_LOAD;
    logic [POS_W-1:0]    position     = '0;
    logic [SYMBOL_W-1:0] symbol       = '0;
    logic                target_first = 1'b0;
    logic                target_last  = 1'b0;
    logic                cfg_valid    = 1'b0;
    logic                cfg_ready;
    logic [LEN_W-1:0]    cfg_data     = '0;
    logic                out_valid;
    logic                out_ready    = 1'b0;
    logic [LEN_W-1:0]    distance;

    distance_scoreboard tracker;

    bit calm;          // no random idling on either side while set
    bit hold_req;      // asks the receiver for one long hold-off
    int idle_cycles;

    // stimulus generator state, kept across phases so a target can stay open
    // over a query length change
    bit in_target;
    int target_left;

    always #4 clk = ~clk;

    bit_parallel_infix_edit_distance_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .position  (position),
        .symbol    (symbol),
        .first     (target_first),
        .last      (target_last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .distance  (distance)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // mostly nucleotide letters in either case so matches are common
    function automatic logic [SYMBOL_W-1:0] pick_symbol();
        if ($urandom_range(0, 4) == 0)
            return SYMBOL_W'($urandom_range(0, 255));
        return DNA_LETTERS[$urandom_range(0, 7)];
    endfunction

    // result side: random stalls, plus the long hold-off on request
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left = gap_length();
            end
        end
    end

    // watch every channel, feed the predictor, check results, run the watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                tracker.note_transaction(command, position, symbol, target_first, target_last);
            if (cfg_valid && cfg_ready)
                tracker.set_query_length(cfg_data);
            if (out_valid && out_ready)
                tracker.check_distance(distance);
            if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // offer one input transaction and hold it until taken; valid stays high
    // afterwards so a back-to-back transaction need not drop and raise it again
    task automatic send(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                        input logic [SYMBOL_W-1:0] sym, input logic starts,
                        input logic ends);
        int gap;
        if (!calm && $urandom_range(0, 2) == 0)
        begin
            gap = gap_length();
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        position     <= pos;
        symbol       <= sym;
        target_first <= starts;
        target_last  <= ends;
        do @(posedge clk); while (!in_ready);
    endtask

    // stop offering and wait for every pending distance, then let the pipe empty
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (tracker.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_target_byte(input logic starts);
        logic ends;
        if (starts)
        begin
            if ($urandom_range(0, 7) == 0)
                target_left = $urandom_range(20, 90);
            else
                target_left = $urandom_range(1, 12);
        end
        target_left--;
        ends      = (target_left <= 0);
        in_target = !ends;
        send(CMD_TARGET, POS_W'($urandom), pick_symbol(), starts, ends);
    endtask

    // mostly whole targets with random content; some loads, empty targets,
    // spare commands and targets that start without a first byte
    task automatic random_items(input int count);
        int done;
        int r;
        done = 0;
        while (done < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                send(CMD_SPARE, POS_W'($urandom), SYMBOL_W'($urandom), 1'($urandom),
                     1'($urandom));
            else
            begin
                done++;
                if (r < 12)
                    send(CMD_LOAD, POS_W'($urandom), pick_symbol(), 1'($urandom),
                         1'($urandom));
                else if (r < 18)
                    send(CMD_EMPTY, POS_W'($urandom), SYMBOL_W'($urandom),
                         1'($urandom), 1'($urandom));
                else if (in_target)
                    send_target_byte(1'b0);
                else if (r < 24)
                begin
                    // broken sequence: carries on from whatever state is left
                    target_left = $urandom_range(1, 6);
                    send_target_byte(1'b0);
                end
                else
                    send_target_byte(1'b1);
            end
        end
    endtask

    // receiver holds off while results keep coming so the block backs up
    task automatic stall_burst();
        calm     = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < BURST_ITEMS; i++)
        begin
            if (i % 2 == 0)
                send(CMD_EMPTY, POS_W'($urandom), SYMBOL_W'($urandom), 1'b0, 1'b0);
            else
                send(CMD_TARGET, POS_W'($urandom), pick_symbol(), 1'b1, 1'b1);
        end
        in_target = 1'b0;
        calm      = 1'b0;
        // sender waits for every result before going on
        drain();
    endtask

    initial
    begin
        logic [LEN_W-1:0] len;
        tracker   = new();
        calm      = 1'b1;
        in_target = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole query store before any target byte reads it
        for (int p = 0; p < QUERY_DEPTH; p++)
            send(CMD_LOAD, POS_W'(p), pick_symbol(), 1'($urandom), 1'($urandom));

        // directed part at the reset query length
        calm = 1'b0;
        send(CMD_EMPTY, 6'd0, 8'h00, 1'b0, 1'b0);
        send(CMD_TARGET, 6'd0, CH_A_LO, 1'b1, 1'b1);         // first and last together
        send(CMD_SPARE, 6'h3F, 8'hFF, 1'b1, 1'b1);           // dropped
        send(CMD_TARGET, 6'd1, CH_C_UP, 1'b1, 1'b0);
        send(CMD_TARGET, 6'd2, CH_G_LO, 1'b0, 1'b0);
        send(CMD_TARGET, 6'd3, CH_T_UP, 1'b0, 1'b1);
        send(CMD_TARGET, 6'h3F, 8'h00, 1'b0, 1'b1);          // continues after a last byte
        send(CMD_TARGET, 6'h2A, 8'hFF, 1'b1, 1'b0);
        send(CMD_TARGET, 6'h15, CH_T_LO, 1'b0, 1'b1);
        send(CMD_LOAD, 6'h3F, 8'hFF, 1'b1, 1'b1);
        send(CMD_LOAD, 6'h00, 8'h00, 1'b0, 1'b0);
        send(CMD_TARGET, 6'd0, 8'hFF, 1'b1, 1'b1);
        send(CMD_TARGET, 6'd0, 8'h00, 1'b1, 1'b1);
        send(CMD_TARGET, 6'd0, CH_A_UP, 1'b1, 1'b0);
        send(CMD_EMPTY, 6'h3F, 8'hFF, 1'b1, 1'b1);           // empty target mid-target
        send(CMD_TARGET, 6'd0, CH_G_UP, 1'b0, 1'b1);
        send(CMD_TARGET, 6'd0, CH_A_UP, 1'b1, 1'b0);
        send(CMD_LOAD, 6'd5, CH_C_LO, 1'b0, 1'b0);           // query edit inside a target
        send(CMD_TARGET, 6'd0, CH_C_UP, 1'b0, 1'b1);
        send(CMD_TARGET, 6'd0, CH_G_LO, 1'b1, 1'b0);         // left open into phase one

        in_target   = 1'b1;
        target_left = 3;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase < 7)
                len = FIXED_LENGTHS[phase];
            else
                len = LEN_W'($urandom_range(0, 127));
            write_length(len);
            calm = (phase % 4 == 3);
            if (phase == 4)
                stall_burst();
            random_items(PHASE_ITEMS);
        end

        drain();
        repeat (10) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/bpied_pkg.sv
rtl/bpied_query_store.sv
rtl/bpied_myers_step.sv
rtl/bit_parallel_infix_edit_distance_core.sv
sim/distance_scoreboard_pkg.sv
sim/testbench.sv
